### hdl/tsn_pkg.sv
// Shared types, constants and character helpers for the text stream normalizer.
// Used by tsn_ctrl, tsn_dp and text_stream_normalizer; depends on nothing.
`default_nettype none

package tsn_pkg;

    // Interior whitespace store
    localparam int GAP_DEPTH = 16;
    localparam int GAP_CNT_W = $clog2(GAP_DEPTH + 1);
    localparam int GAP_IDX_W = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;

    localparam logic [7:0] HEADER_SKIP_RST = 8'd8;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Class of the byte handed to the line stage
    localparam logic [1:0] KIND_NL   = 2'd0;
    localparam logic [1:0] KIND_WS   = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;

    // Source of an emitted byte
    localparam logic [1:0] SRC_CUR = 2'd0;
    localparam logic [1:0] SRC_GAP = 2'd1;
    localparam logic [1:0] SRC_NL  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       sel_op2;
        logic       emit;
        logic [1:0] emit_src;
        logic       ws_store;
        logic       line_close;
        logic       char_done;
        logic       gidx_clr;
        logic       gidx_inc;
        logic       flush;
        logic       text_end;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       cur_valid;
        logic [1:0] cur_kind;
        logic       line_begun;
        logic       gap_any;
        logic       gap_end;
        logic       last;
        logic       can_emit;
        logic       can_flush;
        logic       pend_v;
    } t_sts;

    // Digits and the listed punctuation symbols
    function automatic logic is_listed(input logic [7:0] c);
        logic hit;
        case (c) inside
            [8'h30:8'h39],                              // 0-9
            8'h2E, 8'h2C, 8'h5B, 8'h5D, 8'h7B, 8'h7D,   // . , [ ] { }
            8'h2B, 8'h3D, 8'h2A, 8'h21, 8'h40, 8'h23,   // + = * ! @ #
            8'h24, 8'h25, 8'h5E, 8'h26, 8'h28, 8'h29,   // $ % ^ & ( )
            8'h2D, 8'h5F, 8'h3C, 8'h3E, 8'h3F, 8'h2F,   // - _ < > ? /
            8'h27, 8'h22, 8'h3B, 8'h3A, 8'h60, 8'h7E:   // ' " ; : ` ~
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    // ASCII A-Z to lowercase, all else unchanged
    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/tsn_dp.sv
// Datapath of the text stream normalizer: header skip, three-byte window,
// line-stage state, whitespace store, pending and output registers. Uses tsn_pkg.
`default_nettype none

module tsn_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_wdata,
    input  wire logic [7:0]    i_in_char,
    input  wire logic          i_in_last,
    input  wire tsn_pkg::t_cmd i_cmd,
    output tsn_pkg::t_sts      o_sts,
    input  wire logic          i_m_tready,
    output logic               o_m_tvalid,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast,
    output logic               o_m_tuser
);

    // Text state
    logic [7:0]                   r_header_skip, n_header_skip;
    logic [7:0]                   r_skip_left,   n_skip_left;
    logic [1:0]                   r_fill,        n_fill;
    logic [7:0]                   r_prior,       n_prior;
    logic [7:0]                   r_middle,      n_middle;
    logic                         r_line_begun,  n_line_begun;
    logic [tsn_pkg::GAP_CNT_W-1:0] r_gap_count,  n_gap_count;
    logic                         r_last_tab,    n_last_tab;
    logic                         r_text_open,   n_text_open;

    // Line-stage operations of the current item
    logic       r_op1_v, n_op1_v;
    logic [7:0] r_op1_char, n_op1_char;
    logic       r_op2_v, n_op2_v;
    logic [7:0] r_op2_char, n_op2_char;
    logic       r_last;

    // Whitespace store, 0 = space, 1 = tab
    logic [tsn_pkg::GAP_DEPTH-1:0] r_gap_kinds;
    logic [tsn_pkg::GAP_IDX_W-1:0] r_gidx;

    // One-deep lookahead and output register
    logic       r_pend_v;
    logic [7:0] r_pend_char;
    logic       r_out_v;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic       r_out_done;

    logic       w_apart;
    logic [7:0] w_cur;
    logic       w_cur_v;
    logic       w_cur_tab;
    logic       w_cur_space;
    logic       w_ws_ok;
    logic       w_out_free;
    logic [7:0] w_emit_char;
    logic [7:0] w_skip_load;

    // Select the current line-stage byte and classify it
    assign w_cur       = i_cmd.sel_op2 ? r_op2_char : r_op1_char;
    assign w_cur_v     = i_cmd.sel_op2 ? r_op2_v    : r_op1_v;
    assign w_cur_tab   = (w_cur == tsn_pkg::CH_TAB);
    assign w_cur_space = (w_cur == tsn_pkg::CH_SPACE);

    // Whitespace is stored only inside a line, a space only if it does not follow a stored space, up to the depth
    assign w_ws_ok = r_line_begun
                   && !(w_cur_space && (r_gap_count != '0) && !r_last_tab)
                   && (r_gap_count < tsn_pkg::GAP_CNT_W'(tsn_pkg::GAP_DEPTH));

    assign w_apart     = (r_prior != tsn_pkg::CH_SPACE) && (i_in_char != tsn_pkg::CH_SPACE);
    assign w_skip_load = i_cfg_we ? i_cfg_wdata : r_header_skip;

    // Status toward the controller
    assign w_out_free = !r_out_v || i_m_tready;

    always_comb begin
        o_sts            = '0;
        o_sts.cur_valid  = w_cur_v;
        if (w_cur == tsn_pkg::CH_NL) begin
            o_sts.cur_kind = tsn_pkg::KIND_NL;
        end else if (w_cur_space || w_cur_tab) begin
            o_sts.cur_kind = tsn_pkg::KIND_WS;
        end else begin
            o_sts.cur_kind = tsn_pkg::KIND_CHAR;
        end
        o_sts.line_begun = r_line_begun;
        o_sts.gap_any    = (r_gap_count != '0);
        o_sts.gap_end    = ((tsn_pkg::GAP_CNT_W'(r_gidx) + tsn_pkg::GAP_CNT_W'(1))
                            == r_gap_count);
        o_sts.last       = r_last;
        o_sts.can_emit   = !r_pend_v || w_out_free;
        o_sts.can_flush  = w_out_free;
        o_sts.pend_v     = r_pend_v;
    end

    // Next text state: window on load, line stage on commands, reload at text end, header skip on config write
    always_comb begin
        n_header_skip = r_header_skip;
        n_skip_left   = r_skip_left;
        n_fill        = r_fill;
        n_prior       = r_prior;
        n_middle      = r_middle;
        n_line_begun  = r_line_begun;
        n_gap_count   = r_gap_count;
        n_last_tab    = r_last_tab;
        n_text_open   = r_text_open;
        n_op1_v       = r_op1_v;
        n_op1_char    = r_op1_char;
        n_op2_v       = r_op2_v;
        n_op2_char    = r_op2_char;

        if (i_cmd.load) begin
            n_text_open = 1'b1;
            n_op1_v     = 1'b0;
            n_op1_char  = tsn_pkg::CH_SPACE;
            n_op2_v     = 1'b0;
            n_op2_char  = tsn_pkg::lower_ascii(i_in_char);
            if (r_skip_left != '0) begin
                n_skip_left = r_skip_left - 8'd1;
            end else if (r_fill == 2'd0) begin
                n_prior = i_in_char;
                n_fill  = 2'd1;
            end else if (r_fill == 2'd1) begin
                n_middle = i_in_char;
                n_fill   = 2'd2;
            end else begin
                if (r_middle == tsn_pkg::CH_NL) begin
                    if ((r_prior == tsn_pkg::CH_QUOTE) && (i_in_char == tsn_pkg::CH_QUOTE)) begin
                        n_op1_v    = 1'b1;
                        n_op1_char = tsn_pkg::CH_NL;
                    end else begin
                        n_op1_v    = w_apart;
                    end
                end else if (tsn_pkg::is_listed(r_middle)) begin
                    n_op1_v = w_apart;
                end else begin
                    n_op1_v    = 1'b1;
                    n_op1_char = tsn_pkg::lower_ascii(r_middle);
                end
                n_prior  = r_middle;
                n_middle = i_in_char;
                n_op2_v  = i_in_last && !tsn_pkg::is_listed(i_in_char)
                           && (i_in_char != tsn_pkg::CH_SPACE);
            end
        end

        if (i_cmd.line_close) begin
            n_line_begun = 1'b0;
            n_gap_count  = '0;
        end
        if (i_cmd.char_done) begin
            n_line_begun = 1'b1;
            n_gap_count  = '0;
        end
        if (i_cmd.ws_store && w_ws_ok) begin
            n_gap_count = r_gap_count + tsn_pkg::GAP_CNT_W'(1);
            n_last_tab  = w_cur_tab;
        end

        if (i_cmd.text_end) begin
            n_skip_left  = w_skip_load;
            n_fill       = 2'd0;
            n_prior      = '0;
            n_middle     = '0;
            n_line_begun = 1'b0;
            n_gap_count  = '0;
            n_text_open  = 1'b0;
        end

        if (i_cfg_we) begin
            n_header_skip = i_cfg_wdata;
            if (!r_text_open) begin
                n_skip_left = i_cfg_wdata;
            end
        end
    end

    // Hold text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_skip <= tsn_pkg::HEADER_SKIP_RST;
            r_skip_left   <= tsn_pkg::HEADER_SKIP_RST;
            r_fill        <= 2'd0;
            r_prior       <= '0;
            r_middle      <= '0;
            r_line_begun  <= 1'b0;
            r_gap_count   <= '0;
            r_last_tab    <= 1'b0;
            r_text_open   <= 1'b0;
            r_op1_v       <= 1'b0;
            r_op2_v       <= 1'b0;
            r_last        <= 1'b0;
            r_gidx        <= '0;
        end else begin
            r_header_skip <= n_header_skip;
            r_skip_left   <= n_skip_left;
            r_fill        <= n_fill;
            r_prior       <= n_prior;
            r_middle      <= n_middle;
            r_line_begun  <= n_line_begun;
            r_gap_count   <= n_gap_count;
            r_last_tab    <= n_last_tab;
            r_text_open   <= n_text_open;
            r_op1_v       <= n_op1_v;
            r_op2_v       <= n_op2_v;
            if (i_cmd.load) begin
                r_last <= i_in_last;
            end
            if (i_cmd.gidx_clr) begin
                r_gidx <= '0;
            end else if (i_cmd.gidx_inc) begin
                r_gidx <= r_gidx + tsn_pkg::GAP_IDX_W'(1);
            end
        end
    end

    // Operation bytes and whitespace store carry no reset
    always_ff @(posedge i_clk) begin
        r_op1_char <= n_op1_char;
        r_op2_char <= n_op2_char;
        if (i_cmd.ws_store && w_ws_ok) begin
            r_gap_kinds[r_gap_count[tsn_pkg::GAP_IDX_W-1:0]] <= w_cur_tab;
        end
    end

    // Pick the byte to emit
    always_comb begin
        case (i_cmd.emit_src)
            tsn_pkg::SRC_CUR: w_emit_char = w_cur;
            tsn_pkg::SRC_GAP: w_emit_char = r_gap_kinds[r_gidx] ? tsn_pkg::CH_TAB
                                                                : tsn_pkg::CH_SPACE;
            tsn_pkg::SRC_NL:  w_emit_char = tsn_pkg::CH_NL;
            default:          w_emit_char = tsn_pkg::CH_NL;
        endcase
    end

    // Advance pending and output beat valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_m_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.emit) begin
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end
                r_pend_v <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

    // Move payload: a newer byte pushes the pending one out, flush marks the run end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend_char <= w_emit_char;
            if (r_pend_v) begin
                r_out_char <= r_pend_char;
                r_out_last <= 1'b0;
                r_out_done <= 1'b0;
            end
        end
        if (i_cmd.flush) begin
            r_out_char <= r_pend_char;
            r_out_last <= 1'b1;
            r_out_done <= r_last;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

endmodule

`default_nettype wire

### hdl/tsn_ctrl.sv
// Controller of the text stream normalizer: steps each item through its
// line-stage operations, whitespace flush, line close and run end. Uses tsn_pkg.
`default_nettype none

module tsn_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire tsn_pkg::t_sts i_sts,
    output tsn_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STAGE = 3'd1;
    localparam logic [2:0] S_GAP   = 3'd2;
    localparam logic [2:0] S_CHAR  = 3'd3;
    localparam logic [2:0] S_END   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_sel, n_sel;
    logic       w_advance;

    assign o_s_tready = (r_state == S_IDLE);

    // Sequence the item
    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        o_cmd         = '0;
        o_cmd.sel_op2 = r_sel;
        w_advance     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = 1'b0;
                    n_state    = S_STAGE;
                end
            end
            S_STAGE: begin
                if (!i_sts.cur_valid) begin
                    w_advance = 1'b1;
                end else begin
                    case (i_sts.cur_kind)
                        tsn_pkg::KIND_NL: begin
                            if (!i_sts.line_begun) begin
                                o_cmd.line_close = 1'b1;
                                w_advance        = 1'b1;
                            end else if (i_sts.can_emit) begin
                                o_cmd.emit       = 1'b1;
                                o_cmd.emit_src   = tsn_pkg::SRC_NL;
                                o_cmd.line_close = 1'b1;
                                w_advance        = 1'b1;
                            end
                        end
                        tsn_pkg::KIND_WS: begin
                            o_cmd.ws_store = 1'b1;
                            w_advance      = 1'b1;
                        end
                        default: begin
                            if (i_sts.line_begun && i_sts.gap_any) begin
                                o_cmd.gidx_clr = 1'b1;
                                n_state        = S_GAP;
                            end else if (i_sts.can_emit) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_src  = tsn_pkg::SRC_CUR;
                                o_cmd.char_done = 1'b1;
                                w_advance       = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_GAP: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = tsn_pkg::SRC_GAP;
                    o_cmd.gidx_inc = 1'b1;
                    if (i_sts.gap_end) begin
                        n_state = S_CHAR;
                    end
                end
            end
            S_CHAR: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_src  = tsn_pkg::SRC_CUR;
                    o_cmd.char_done = 1'b1;
                    w_advance       = 1'b1;
                end
            end
            S_END: begin
                if (i_sts.last && i_sts.line_begun) begin
                    if (i_sts.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = tsn_pkg::SRC_NL;
                        n_state        = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_v) begin
                    o_cmd.text_end = i_sts.last;
                    n_state        = S_IDLE;
                end else if (i_sts.can_flush) begin
                    o_cmd.flush    = 1'b1;
                    o_cmd.text_end = i_sts.last;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Step to the second operation, then to the line close
        if (w_advance) begin
            if (!r_sel) begin
                n_sel   = 1'b1;
                n_state = S_STAGE;
            end else begin
                n_state = S_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

`default_nettype wire

### hdl/text_stream_normalizer.sv
// Text stream normalizer: one input beat per item, each causing zero or more output beats.
// Each item steps through accept, two line-stage steps, line close and run end;
// stored gaps ahead of a byte are flushed in the gap and char states, and output stalls
// hold the sequence. A new item is taken only once the controller is back in idle.
// Reset (i_rst_n low, synchronous): header skip back to 8, window and line state cleared.
// Instantiates tsn_ctrl and tsn_dp; uses tsn_pkg.
`default_nettype none

module text_stream_normalizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,   // header_skip
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,     // [7:0] in_char
    input  wire logic       i_s_tlast,     // end_of_text
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,     // [7:0] out_char
    output logic            o_m_tlast,     // run_last
    output logic            o_m_tuser      // [0] text_done
);

    tsn_pkg::t_cmd w_cmd;
    tsn_pkg::t_sts w_sts;

    tsn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tsn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_char   (i_s_tdata),
        .i_in_last   (i_s_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    // No byte may be left pending when a new item is taken
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_sts.pend_v)
        else $error("pending byte left over at item accept");

    // Text end is only flagged on the last beat of a run
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("text_done without run_last");

    // A flush always moves a pending byte into the output register
    a_flush_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.flush |-> (w_sts.pend_v && w_sts.can_flush))
        else $error("flush without a pending byte or free output");

endmodule

`default_nettype wire
